@@ design/wbcp_pkg.sv @@
// Package for the weighted base count pileup block.
// Holds the field widths, the code and slot constants, the weight ROM and the stage-to-stage types.
// No dependencies; every other design file imports it.
package wbcp_pkg;

    // Sizing of the accumulators and the weights
    localparam int unsigned MAX_DEPTH        = 8192;
    localparam int unsigned WEIGHT_FRAC_BITS = 16;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned QUAL_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned COUNT_W = 16;

    localparam int unsigned NUM_SUMS = 6;
    localparam int unsigned SUM_W    = $clog2(MAX_DEPTH) + WEIGHT_FRAC_BITS;
    localparam int unsigned MUL_W    = 2 * WEIGHT_FRAC_BITS;
    localparam int unsigned CONV_W   = (SUM_W + 4 > WEIGHT_FRAC_BITS + COUNT_W) ?
                                       SUM_W + 4 : WEIGHT_FRAC_BITS + COUNT_W;

    localparam logic [SUM_W-1:0] SUM_LIMIT =
        SUM_W'((64'(MAX_DEPTH) << WEIGHT_FRAC_BITS) - 64'd1);
    localparam logic [MUL_W-1:0] MUL_HALF = MUL_W'(64'd1 << (WEIGHT_FRAC_BITS - 1));
    localparam logic [CONV_W-1:0] CONV_HALF = CONV_W'(64'd1 << (WEIGHT_FRAC_BITS - 1));
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Indel kinds
    localparam logic [KIND_W-1:0] INDEL_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] INDEL_DELETE = 2'd2;

    // One-hot base codes
    localparam logic [CODE_W-1:0] BASE_A = 4'd1;
    localparam logic [CODE_W-1:0] BASE_C = 4'd2;
    localparam logic [CODE_W-1:0] BASE_G = 4'd4;
    localparam logic [CODE_W-1:0] BASE_T = 4'd8;

    // Accumulator slots
    localparam int unsigned SLOT_A   = 0;
    localparam int unsigned SLOT_C   = 1;
    localparam int unsigned SLOT_G   = 2;
    localparam int unsigned SLOT_T   = 3;
    localparam int unsigned SLOT_INS = 4;
    localparam int unsigned SLOT_DEL = 5;

    // Weight ROM: entry q = 1 - e^(-0.1*q) in unsigned Q0.F
    localparam logic [63:0] EXP_STEP_Q32 = 64'd3886247119;
    localparam logic [63:0] WEIGHT_MAX   = (64'd1 << WEIGHT_FRAC_BITS) - 64'd1;

    typedef logic [255:0][WEIGHT_FRAC_BITS-1:0] weight_rom_t;

    function automatic weight_rom_t build_weight_rom();
        weight_rom_t rom;
        logic [63:0] e;
        logic [63:0] r;
        logic [63:0] w;
        rom = '0;
        e   = 64'd1 << 32;
        for (int q = 1; q < 256; q++)
        begin
            e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
            r = (64'd1 << 32) - e;
            w = (r + (64'd1 << (31 - WEIGHT_FRAC_BITS))) >> (32 - WEIGHT_FRAC_BITS);
            if (w > WEIGHT_MAX)
            begin
                w = WEIGHT_MAX;
            end
            rom[q] = w[WEIGHT_FRAC_BITS-1:0];
        end
        return rom;
    endfunction

    localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

    // Weighted contribution of one entry, headed for the accumulators
    typedef struct packed {
        logic                        valid;
        logic                        last;
        logic [POS_W-1:0]            position;
        logic [NUM_SUMS-1:0]         slot;
        logic [WEIGHT_FRAC_BITS-1:0] value;
    } contrib_t;

    // Closed column: final sums waiting for conversion
    typedef struct packed {
        logic                            valid;
        logic [POS_W-1:0]                position;
        logic [NUM_SUMS-1:0][SUM_W-1:0]  sums;
    } snap_t;

endpackage

@@ design/wbcp_entry_if.sv @@
// Read entry channel: valid/ready handshake plus the fields of one pileup entry.
// Depends on wbcp_pkg for the field widths.
interface wbcp_entry_if
    import wbcp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  position;
    logic              entry_present;
    logic [QUAL_W-1:0] map_quality;
    logic [KIND_W-1:0] indel_kind;
    logic              is_deleted;
    logic [CODE_W-1:0] base_code;
    logic [QUAL_W-1:0] base_quality;
    logic              last_in_column;

    modport source (
        output valid, position, entry_present, map_quality, indel_kind,
               is_deleted, base_code, base_quality, last_in_column,
        input  ready
    );

    modport sink (
        input  valid, position, entry_present, map_quality, indel_kind,
               is_deleted, base_code, base_quality, last_in_column,
        output ready
    );
endinterface

@@ design/wbcp_count_if.sv @@
// Column count channel: valid/ready handshake plus the six counts of one column.
// Depends on wbcp_pkg for the field widths.
interface wbcp_count_if
    import wbcp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   out_position;
    logic [COUNT_W-1:0] count_a;
    logic [COUNT_W-1:0] count_c;
    logic [COUNT_W-1:0] count_g;
    logic [COUNT_W-1:0] count_t;
    logic [COUNT_W-1:0] count_insertion;
    logic [COUNT_W-1:0] count_deletion;

    modport source (
        output valid, out_position, count_a, count_c, count_g, count_t,
               count_insertion, count_deletion,
        input  ready
    );

    modport sink (
        input  valid, out_position, count_a, count_c, count_g, count_t,
               count_insertion, count_deletion,
        output ready
    );
endinterface

@@ design/weighted_base_count_pileup.sv @@
// Top level of the weighted base count pileup block.
// Depends on wbcp_pkg, wbcp_entry_if, wbcp_count_if, wbcp_weight_stage, wbcp_accum and
// wbcp_count_out.
//
// Feed the read entries of one alignment column on "entries", one transfer per entry; the
// entry with last_in_column set closes the column, and one transfer on "counts" then carries
// its position and the six counts (A, C, G, T, insertion, deletion), each round(10*sum)
// saturated at 65535. An entry with entry_present low adds nothing but still closes the
// column when flagged last. The block takes one entry per clock cycle as long as the count
// channel keeps up; it is a four-register pipeline (input, weighted contribution, closed
// column, result), and a column's counts are offered once its last entry has passed all
// four. Each entry passes through one weight ROM lookup pair and one 16x16 multiply, then
// one saturating add into its sum. A stalled count channel fills the pipeline back to the
// entry port; entries that do not close a column keep flowing while one closed column and
// one result wait.
module weighted_base_count_pileup
    import wbcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    wbcp_entry_if.sink    entries,
    wbcp_count_if.source  counts
);

    contrib_t contrib;
    logic     contrib_take;
    snap_t    snap;
    logic     snap_take;

    wbcp_weight_stage u_weight_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .entries      (entries),
        .contrib_take (contrib_take),
        .contrib      (contrib)
    );

    wbcp_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .contrib      (contrib),
        .contrib_take (contrib_take),
        .snap         (snap),
        .snap_take    (snap_take)
    );

    wbcp_count_out u_count_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .snap      (snap),
        .snap_take (snap_take),
        .counts    (counts)
    );

endmodule

@@ design/wbcp_weight_stage.sv @@
// Input register, weight ROM lookups and base-quality multiply for one entry.
// Depends on wbcp_pkg and wbcp_entry_if; feeds wbcp_accum.
module wbcp_weight_stage
    import wbcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    wbcp_entry_if.sink    entries,
    input  logic          contrib_take,
    output contrib_t      contrib
);

    logic                        in_valid_reg;
    logic [POS_W-1:0]            position_reg;
    logic                        present_reg;
    logic [QUAL_W-1:0]           map_quality_reg;
    logic [KIND_W-1:0]           indel_kind_reg;
    logic                        deleted_reg;
    logic [CODE_W-1:0]           base_code_reg;
    logic [QUAL_W-1:0]           base_quality_reg;
    logic                        last_reg;

    logic                        c_valid_reg;
    logic                        c_last_reg;
    logic [POS_W-1:0]            c_position_reg;
    logic [NUM_SUMS-1:0]         c_slot_reg;
    logic [WEIGHT_FRAC_BITS-1:0] c_value_reg;

    logic                        advance;
    logic [WEIGHT_FRAC_BITS-1:0] map_weight;
    logic [WEIGHT_FRAC_BITS-1:0] base_weight;
    logic [MUL_W-1:0]            product;
    logic [MUL_W-1:0]            product_rnd;
    logic [NUM_SUMS-1:0]         slot_next;
    logic [WEIGHT_FRAC_BITS-1:0] value_next;

    // Move the held entry on when the contribution register frees up
    assign advance       = in_valid_reg && (!c_valid_reg || contrib_take);
    assign entries.ready = !in_valid_reg || advance;

    // Hold the accepted entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (entries.ready)
        begin
            in_valid_reg <= entries.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entries.ready && entries.valid)
        begin
            position_reg     <= entries.position;
            present_reg      <= entries.entry_present;
            map_quality_reg  <= entries.map_quality;
            indel_kind_reg   <= entries.indel_kind;
            deleted_reg      <= entries.is_deleted;
            base_code_reg    <= entries.base_code;
            base_quality_reg <= entries.base_quality;
            last_reg         <= entries.last_in_column;
        end
    end

    // Look up both weights, multiply and round back to Q0.F
    assign map_weight  = WEIGHT_ROM[map_quality_reg];
    assign base_weight = WEIGHT_ROM[base_quality_reg];
    assign product     = MUL_W'(map_weight) * MUL_W'(base_weight);
    assign product_rnd = product + MUL_HALF;

    // Pick the target sum and the value to add
    always_comb
    begin
        slot_next  = '0;
        value_next = map_weight;
        if (present_reg && (map_quality_reg != '0))
        begin
            case (indel_kind_reg)
                INDEL_INSERT: slot_next[SLOT_INS] = 1'b1;
                INDEL_DELETE: slot_next[SLOT_DEL] = 1'b1;
                default:
                begin
                    value_next = product_rnd[MUL_W-1:WEIGHT_FRAC_BITS];
                    if (!deleted_reg)
                    begin
                        case (base_code_reg)
                            BASE_A:  slot_next[SLOT_A] = 1'b1;
                            BASE_C:  slot_next[SLOT_C] = 1'b1;
                            BASE_G:  slot_next[SLOT_G] = 1'b1;
                            BASE_T:  slot_next[SLOT_T] = 1'b1;
                            default: slot_next = '0;
                        endcase
                    end
                end
            endcase
        end
    end

    // Contribution register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            c_valid_reg <= 1'b1;
        end
        else if (contrib_take)
        begin
            c_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_last_reg     <= last_reg;
            c_position_reg <= position_reg;
            c_slot_reg     <= slot_next;
            c_value_reg    <= value_next;
        end
    end

    assign contrib.valid    = c_valid_reg;
    assign contrib.last     = c_last_reg;
    assign contrib.position = c_position_reg;
    assign contrib.slot     = c_slot_reg;
    assign contrib.value    = c_value_reg;

endmodule

@@ design/wbcp_accum.sv @@
// Six saturating column accumulators and the register that holds a closed column's sums.
// Depends on wbcp_pkg; sits between wbcp_weight_stage and wbcp_count_out.
module wbcp_accum
    import wbcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  contrib_t  contrib,
    output logic      contrib_take,
    output snap_t     snap,
    input  logic      snap_take
);

    logic [NUM_SUMS-1:0][SUM_W-1:0] sums_reg;
    logic [NUM_SUMS-1:0][SUM_W-1:0] sums_next;
    logic [SUM_W:0]                 wide_sum;

    logic                           snap_valid_reg;
    logic [POS_W-1:0]               snap_position_reg;
    logic [NUM_SUMS-1:0][SUM_W-1:0] snap_sums_reg;

    logic                           close_column;

    // A closing entry waits until the snapshot register is free
    assign contrib_take = contrib.valid &&
                          (!contrib.last || !snap_valid_reg || snap_take);
    assign close_column = contrib_take && contrib.last;

    // Add the contribution to its sum, saturate at the depth limit
    always_comb
    begin
        wide_sum = '0;
        for (int k = 0; k < NUM_SUMS; k++)
        begin
            wide_sum = {1'b0, sums_reg[k]};
            if (contrib.slot[k])
            begin
                wide_sum = wide_sum + (SUM_W + 1)'(contrib.value);
            end
            if (wide_sum > {1'b0, SUM_LIMIT})
            begin
                sums_next[k] = SUM_LIMIT;
            end
            else
            begin
                sums_next[k] = wide_sum[SUM_W-1:0];
            end
        end
    end

    // Accumulate; clear when the column closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg <= '0;
        end
        else if (close_column)
        begin
            sums_reg <= '0;
        end
        else if (contrib_take)
        begin
            sums_reg <= sums_next;
        end
    end

    // Hold the closed column until conversion takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (close_column)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (snap_take)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (close_column)
        begin
            snap_position_reg <= contrib.position;
            snap_sums_reg     <= sums_next;
        end
    end

    assign snap.valid    = snap_valid_reg;
    assign snap.position = snap_position_reg;
    assign snap.sums     = snap_sums_reg;

endmodule

@@ design/wbcp_count_out.sv @@
// Converts closed-column sums to round(10*sum) counts, saturated, into the result register.
// Depends on wbcp_pkg and wbcp_count_if; fed by wbcp_accum.
module wbcp_count_out
    import wbcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  snap_t         snap,
    output logic          snap_take,
    wbcp_count_if.source  counts
);

    logic                             out_valid_reg;
    logic [POS_W-1:0]                 position_reg;
    logic [NUM_SUMS-1:0][COUNT_W-1:0] count_reg;
    logic [NUM_SUMS-1:0][COUNT_W-1:0] count_next;

    logic [CONV_W-1:0]                  scaled;
    logic [CONV_W-WEIGHT_FRAC_BITS-1:0] whole;

    assign snap_take = snap.valid && (!out_valid_reg || counts.ready);

    // Scale by ten with shifts, round half up, drop the fraction, saturate
    always_comb
    begin
        scaled = '0;
        whole  = '0;
        for (int k = 0; k < NUM_SUMS; k++)
        begin
            scaled = (CONV_W'(snap.sums[k]) << 3) + (CONV_W'(snap.sums[k]) << 1) + CONV_HALF;
            whole  = scaled[CONV_W-1:WEIGHT_FRAC_BITS];
            if ((whole >> COUNT_W) != '0)
            begin
                count_next[k] = COUNT_MAX;
            end
            else
            begin
                count_next[k] = whole[COUNT_W-1:0];
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (snap_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (counts.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            position_reg <= snap.position;
            count_reg    <= count_next;
        end
    end

    assign counts.valid           = out_valid_reg;
    assign counts.out_position    = position_reg;
    assign counts.count_a         = count_reg[SLOT_A];
    assign counts.count_c         = count_reg[SLOT_C];
    assign counts.count_g         = count_reg[SLOT_G];
    assign counts.count_t         = count_reg[SLOT_T];
    assign counts.count_insertion = count_reg[SLOT_INS];
    assign counts.count_deletion  = count_reg[SLOT_DEL];

endmodule
